[design/bsts_pkg.sv]
// bsts_pkg: shared types and codes for the bounded sorted timestamp table
// used by bsts_cell and bounded_sorted_timestamp_table
package bsts_pkg;

  localparam logic [1:0] MODE_CLEAR  = 2'd0;
  localparam logic [1:0] MODE_INSERT = 2'd1;
  localparam logic [1:0] MODE_FIND   = 2'd2;

  localparam int TIME_W  = 32;
  localparam int COUNT_W = 6;

  typedef struct packed {
    logic [1:0]        mode;
    logic [TIME_W-1:0] time_value;
  } bsts_in_t;

  typedef struct packed {
    logic [COUNT_W-1:0] entry_count;
    logic               evicted;
    logic [TIME_W-1:0]  evicted_time;
    logic               found;
    logic [TIME_W-1:0]  found_time;
  } bsts_out_t;

  // broadcast to every cell
  typedef struct packed {
    logic              clear;
    logic              insert;
    logic [TIME_W-1:0] ins_value;
    logic [TIME_W-1:0] key;
  } bsts_ctrl_t;

  // handed from one cell to its right neighbor
  typedef struct packed {
    logic              valid;
    logic [TIME_W-1:0] value;
    logic              gt;
    logic              hit;
    logic [TIME_W-1:0] carry;
  } bsts_link_t;

endpackage

[design/bsts_cell.sv]
// bsts_cell: one slot of the sorted chain, holds a timestamp and a find carry
// depends on bsts_pkg
module bsts_cell (
  input  logic                clk,
  input  logic                rst,
  input  bsts_pkg::bsts_ctrl_t ctrl,
  input  bsts_pkg::bsts_link_t prev,
  input  logic                next_valid,
  input  logic                tail,
  output bsts_pkg::bsts_link_t link
);
  import bsts_pkg::*;

  logic              valid;
  logic [TIME_W-1:0] value;
  logic [TIME_W-1:0] carry;
  logic              gt_own;
  logic              hit_own;
  logic              sel;

  always_comb begin
    gt_own  = valid && (value > ctrl.ins_value) && !tail;
    hit_own = valid && (value <= ctrl.key);
    // floor entry, or oldest entry when nothing lies at or below the key
    sel     = (hit_own && !prev.hit) || (valid && !next_valid && !hit_own);
    link.valid = valid;
    link.value = value;
    link.gt    = gt_own;
    link.hit   = hit_own;
    link.carry = carry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.clear) begin
      valid <= 1'b0;
    end else if (ctrl.insert) begin
      valid <= valid | prev.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.insert && !gt_own) begin
      value <= prev.gt ? ctrl.ins_value : prev.value;
    end
    carry <= sel ? value : prev.carry;
  end

endmodule

[design/bounded_sorted_timestamp_table.sv]
// bounded_sorted_timestamp_table: top level, chain of bsts_cell slots plus
// transaction control and the result register; depends on bsts_pkg, bsts_cell
//
// Usage:
//   in_valid/in_stall/in_data carry one transaction: mode and time_value.
//   out_valid/out_stall/out_data return one result per transaction.
//   Clear, insert and unused modes finish at the accepting edge; the result
//   is registered at that edge. A find passes a carry through the cell chain,
//   one cell per cycle; its result is registered when a timer loaded with
//   CAPACITY at accept counts down to zero. Throughput: one clear or insert
//   per cycle when out_stall is low; no input is taken while a find is busy.
//   The next transaction is taken while a result waits, as long as the result
//   register is empty or being taken and no find is in flight.
//   When the receiver stalls, the result holds and input stalls behind it.
//   Reset empties the table and drops any pending result; stored timestamps
//   are not cleared, only the per-cell valid bits.
//   Entries are sorted newest first; a full insert evicts the oldest.
module bounded_sorted_timestamp_table #(
  parameter int CAPACITY = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  bsts_pkg::bsts_in_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output bsts_pkg::bsts_out_t  out_data
);
  import bsts_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);

  bsts_ctrl_t        ctrl;
  bsts_link_t        links [CAPACITY];
  bsts_link_t        head;
  logic              busy;
  logic [CW-1:0]     timer;
  logic [CW-1:0]     count;
  logic [TIME_W-1:0] key;
  logic              accept;
  logic              full;

  assign in_stall = busy || (out_valid && out_stall);
  assign accept   = in_valid && !in_stall;
  assign full     = links[CAPACITY-1].valid;

  always_comb begin
    ctrl.clear     = accept && (in_data.mode == MODE_CLEAR);
    ctrl.insert    = accept && (in_data.mode == MODE_INSERT);
    ctrl.ins_value = in_data.time_value;
    ctrl.key       = key;
    head.valid     = 1'b1;
    head.value     = '0;
    head.gt        = 1'b1;
    head.hit       = 1'b0;
    head.carry     = '0;
  end

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      bsts_cell u_cell (
        .clk        (clk),
        .rst        (rst),
        .ctrl       (ctrl),
        .prev       ((g == 0) ? head : links[(g == 0) ? 0 : g-1]),
        .next_valid ((g == CAPACITY-1) ? 1'b0 : links[(g == CAPACITY-1) ? g : g+1].valid),
        .tail       ((g == CAPACITY-1) ? 1'b1 : 1'b0),
        .link       (links[g])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      timer     <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else if (accept) begin
      case (in_data.mode)
        MODE_CLEAR: begin
          count     <= '0;
          out_valid <= 1'b1;
        end
        MODE_INSERT: begin
          if (!full) begin
            count <= count + CW'(1);
          end
          out_valid <= 1'b1;
        end
        MODE_FIND: begin
          busy      <= 1'b1;
          timer     <= CW'(CAPACITY);
          out_valid <= 1'b0;
        end
        default: begin
          out_valid <= 1'b1;
        end
      endcase
    end else if (busy) begin
      if (timer == '0) begin
        busy      <= 1'b0;
        out_valid <= 1'b1;
      end else begin
        timer <= timer - CW'(1);
      end
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      key                   <= in_data.time_value;
      out_data.evicted      <= (in_data.mode == MODE_INSERT) && full;
      out_data.evicted_time <= ((in_data.mode == MODE_INSERT) && full) ?
                               links[CAPACITY-1].value : '0;
      out_data.found        <= 1'b0;
      out_data.found_time   <= '0;
      case (in_data.mode)
        MODE_CLEAR: begin
          out_data.entry_count <= '0;
        end
        MODE_INSERT: begin
          out_data.entry_count <= full ? COUNT_W'(count) : COUNT_W'(count + CW'(1));
        end
        default: begin
          out_data.entry_count <= COUNT_W'(count);
        end
      endcase
    end else if (busy && (timer == '0)) begin
      out_data.found      <= (count != '0);
      out_data.found_time <= (count != '0) ? links[CAPACITY-1].carry : '0;
    end
  end

endmodule
